>>> src/qtd_pkg.sv
// ----------------------------------------------------------------------------
// qtd_pkg
// shared constants and types of the quadtree image stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package qtd_pkg;

   // deepest tree level, log2 of the largest image side
   localparam int MAX_LOG_SIZE = 10;

   localparam int LOG_W   = 4;
   localparam int POS_W   = MAX_LOG_SIZE;
   localparam int DEPTH_W = $clog2(MAX_LOG_SIZE + 1);
   localparam int GRAY_W  = 8;
   localparam int QUAD_W  = 2;

   localparam logic [LOG_W-1:0]  LOG_SIZE_RESET = LOG_W'(9);
   localparam logic [LOG_W-1:0]  LOG_SIZE_MAX   = LOG_W'(MAX_LOG_SIZE);

   // flag byte codes
   localparam logic [GRAY_W-1:0] FLAG_SPLIT = GRAY_W'(0);
   localparam logic [GRAY_W-1:0] FLAG_LEAF  = GRAY_W'(1);

   // bottom-right quadrant, last child of a split
   localparam logic [QUAD_W-1:0] QUAD_LAST = QUAD_W'(3);

   typedef struct packed {
      logic [POS_W-1:0]  fill_x;
      logic [POS_W-1:0]  fill_y;
      logic [LOG_W-1:0]  fill_log_side;
      logic [GRAY_W-1:0] gray_level;
      logic              is_fill;
      logic              image_done;
      logic              split_error;
   } result_type;

endpackage

`default_nettype wire

>>> src/qtd_if.sv
// ----------------------------------------------------------------------------
// qtd_if
// valid/ready channels of the decoder: coded bytes in, fill commands out
// ----------------------------------------------------------------------------
`default_nettype none

interface qtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface qtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] fill_x;
   logic [9:0] fill_y;
   logic [3:0] fill_log_side;
   logic [7:0] gray_level;
   logic       is_fill;
   logic       image_done;
   logic       split_error;

   modport source (output valid, output fill_x, output fill_y, output fill_log_side,
                   output gray_level, output is_fill, output image_done,
                   output split_error, input ready);
   modport sink   (input valid, input fill_x, input fill_y, input fill_log_side,
                   input gray_level, input is_fill, input image_done,
                   input split_error, output ready);
endinterface

`default_nettype wire

>>> src/quadtree_image_stream_decoder.sv
// a byte accepted waits in the input register, then the decode step puts its fill command in the result register
// throughput: one byte per cycle, sustained while the result side keeps up;
//    the decode step (flag test, stack push or pop find over ten levels) is combinational
// reset: synchronous, active high; log_size returns to 9, the walk restarts at the root
//    and both pipeline registers empty; a csr write also restarts the walk
// ----------------------------------------------------------------------------
// quadtree_image_stream_decoder
// turns a depth-first quadtree byte stream into square fill commands
// ----------------------------------------------------------------------------
`default_nettype none

module quadtree_image_stream_decoder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   qtd_req_if.sink                         req_if,
   qtd_rsp_if.source                       rsp_if,
   input  wire logic                       csr_wr_en,
   input  wire logic [qtd_pkg::LOG_W-1:0]  csr_wr_data
);
   import qtd_pkg::*;

   // input register: one coded byte waiting for the decode step
   logic              in_valid_ff;
   logic [GRAY_W-1:0] in_byte_ff;

   // result register: one fill command waiting to be taken
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff;

   logic              step_en;
   logic              core_valid;
   result_type        core_res;

   // the decode step runs when the result register is free or being emptied
   assign step_en       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || step_en;

   qtd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .step_byte   (in_byte_ff),
      .res_valid   (core_valid),
      .res         (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.stream_byte;
      end
   end

   // a step that makes no result still frees the register if it was taken
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (step_en) begin
         out_valid_in = core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && core_valid) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.fill_x        = out_res_ff.fill_x;
   assign rsp_if.fill_y        = out_res_ff.fill_y;
   assign rsp_if.fill_log_side = out_res_ff.fill_log_side;
   assign rsp_if.gray_level    = out_res_ff.gray_level;
   assign rsp_if.is_fill       = out_res_ff.is_fill;
   assign rsp_if.image_done    = out_res_ff.image_done;
   assign rsp_if.split_error   = out_res_ff.split_error;

endmodule

`default_nettype wire

>>> src/qtd_core.sv
// ----------------------------------------------------------------------------
// qtd_core
// tree walk state and one-byte decode step with quadrant path stack
// ----------------------------------------------------------------------------
`default_nettype none

module qtd_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [qtd_pkg::LOG_W-1:0]     csr_wr_data,
   input  wire logic                          step_en,
   input  wire logic [qtd_pkg::GRAY_W-1:0]    step_byte,
   output logic                               res_valid,
   output qtd_pkg::result_type                res
);
   import qtd_pkg::*;

   logic [LOG_W-1:0]   log_size_ff;
   logic               expect_gray_ff, expect_gray_in;
   logic               finished_ff, finished_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [QUAD_W-1:0]  path_ff [MAX_LOG_SIZE];
   logic [QUAD_W-1:0]  path_in [MAX_LOG_SIZE];

   logic [LOG_W-1:0]   eff_log;
   logic [POS_W-1:0]   x_full, y_full;
   logic [DEPTH_W-1:0] pop_depth;
   logic               pop_found;

   assign eff_log = (log_size_ff > LOG_SIZE_MAX) ? LOG_SIZE_MAX : log_size_ff;

   // position: level i sets bit (top - i), then shift down to the image size
   always_comb begin
      x_full = '0;
      y_full = '0;
      for (int i = 0; i < MAX_LOG_SIZE; i++) begin
         if (DEPTH_W'(i) < depth_ff) begin
            x_full[MAX_LOG_SIZE-1-i] = path_ff[i][0];
            y_full[MAX_LOG_SIZE-1-i] = path_ff[i][1];
         end
      end
   end

   // pop: deepest level below depth whose quadrant is not the last one
   always_comb begin
      pop_depth = '0;
      pop_found = 1'b0;
      for (int i = 0; i < MAX_LOG_SIZE; i++) begin
         if (DEPTH_W'(i) < depth_ff && path_ff[i] != QUAD_LAST) begin
            pop_depth = DEPTH_W'(i + 1);
            pop_found = 1'b1;
         end
      end
   end

   always_comb begin
      logic do_adv;
      do_adv         = 1'b0;
      expect_gray_in = expect_gray_ff;
      finished_in    = finished_ff;
      depth_in       = depth_ff;
      path_in        = path_ff;
      res_valid      = 1'b0;
      res.fill_x        = x_full >> (LOG_W'(MAX_LOG_SIZE) - eff_log);
      res.fill_y        = y_full >> (LOG_W'(MAX_LOG_SIZE) - eff_log);
      res.fill_log_side = eff_log - LOG_W'(depth_ff);
      res.gray_level    = '0;
      res.is_fill       = 1'b0;
      res.image_done    = 1'b0;
      res.split_error   = 1'b0;

      if (!finished_ff) begin
         if (expect_gray_ff) begin
            expect_gray_in = 1'b0;
            res.gray_level = step_byte;
            res.is_fill    = 1'b1;
            res_valid      = 1'b1;
            do_adv         = 1'b1;
         end else if (step_byte == FLAG_LEAF) begin
            expect_gray_in = 1'b1;
         end else if (step_byte == FLAG_SPLIT) begin
            if (LOG_W'(depth_ff) >= eff_log) begin
               res.split_error = 1'b1;
               res_valid       = 1'b1;
               do_adv          = 1'b1;
            end else begin
               for (int i = 0; i < MAX_LOG_SIZE; i++) begin
                  if (DEPTH_W'(i) == depth_ff) begin
                     path_in[i] = '0;
                  end
               end
               depth_in = depth_ff + DEPTH_W'(1);
            end
         end else begin
            // unknown flag skips the node, visible only when it ends the image
            do_adv    = 1'b1;
            res_valid = !pop_found;
         end
      end

      if (do_adv) begin
         res.image_done = !pop_found;
         finished_in    = !pop_found;
         depth_in       = pop_depth;
         for (int i = 0; i < MAX_LOG_SIZE; i++) begin
            if (pop_found && DEPTH_W'(i + 1) == pop_depth) begin
               path_in[i] = path_ff[i] + QUAD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_size_ff    <= LOG_SIZE_RESET;
         expect_gray_ff <= 1'b0;
         finished_ff    <= 1'b0;
         depth_ff       <= '0;
         for (int i = 0; i < MAX_LOG_SIZE; i++) path_ff[i] <= '0;
      end else if (csr_wr_en) begin
         log_size_ff    <= csr_wr_data;
         expect_gray_ff <= 1'b0;
         finished_ff    <= 1'b0;
         depth_ff       <= '0;
         for (int i = 0; i < MAX_LOG_SIZE; i++) path_ff[i] <= '0;
      end else if (step_en) begin
         expect_gray_ff <= expect_gray_in;
         finished_ff    <= finished_in;
         depth_ff       <= depth_in;
         path_ff        <= path_in;
      end
   end

endmodule

`default_nettype wire

>>> src/qtd_checker.sv
// ----------------------------------------------------------------------------
// qtd_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module qtd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [9:0] rsp_fill_x,
   input wire logic [3:0] rsp_fill_log_side,
   input wire logic [7:0] rsp_gray_level,
   input wire logic       rsp_is_fill,
   input wire logic       rsp_image_done,
   input wire logic       rsp_split_error
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fill_x) &&
      $stable(rsp_gray_level) && $stable(rsp_image_done))
      else $error("result item changed while stalled");

   a_fill_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_fill |-> !rsp_split_error)
      else $error("fill item marked as split error");

   a_nofill_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_fill |-> rsp_gray_level == 8'd0)
      else $error("non-fill item carries a gray level");

   a_err_one_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_split_error |-> rsp_fill_log_side == 4'd0)
      else $error("split error on a square larger than one pixel");

   // the walk stops at done, nothing follows right after the last item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_image_done |=> !rsp_valid)
      else $error("item delivered right after image done");

endmodule

bind quadtree_image_stream_decoder qtd_checker u_qtd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_fill_x        (rsp_if.fill_x),
   .rsp_fill_log_side (rsp_if.fill_log_side),
   .rsp_gray_level    (rsp_if.gray_level),
   .rsp_is_fill       (rsp_if.is_fill),
   .rsp_image_done    (rsp_if.image_done),
   .rsp_split_error   (rsp_if.split_error)
);

`default_nettype wire
